### src/q931_ie_index_builder_macros.svh
// Assertion helpers used by the index engine RTL (q931_ie_back).
// All macros assume signals clk and rst_n in scope.
`ifndef Q931_IE_INDEX_BUILDER_MACROS_SVH
`define Q931_IE_INDEX_BUILDER_MACROS_SVH

// Property holds at every clock outside reset.
`define Q931_IE_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define Q931_IE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define Q931_IE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/q931_ie_pkg.sv
// ----------------------------------------------------------------------------
// q931_ie_pkg
// Types, codes and the code-to-slot table of the Q.931 IE index builder.
// ----------------------------------------------------------------------------
package q931_ie_pkg;

    localparam int EXT_SLOTS_DEF = 8;
    localparam int MSG_BYTES_DEF = 4096;

    localparam int NUM_MAIN   = 32;
    localparam int MAIN_W     = 5;
    localparam int NUM_SINGLE = 3;
    localparam int SEL_W      = 2;

    localparam logic [5:0] SINGLE_BASE = 6'd32;
    localparam logic [5:0] EXT_BASE    = 6'd35;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    localparam logic [7:0] SINGLE_FLAG   = 8'h80;
    localparam logic [7:0] HI_NIBBLE     = 8'hf0;
    localparam logic [7:0] CODE_MORE     = 8'ha0;
    localparam logic [7:0] CODE_COMPLETE = 8'ha1;
    localparam logic [7:0] CODE_CONGEST  = 8'hb0;

    localparam logic [SEL_W-1:0] SEL_MORE     = 2'd0;
    localparam logic [SEL_W-1:0] SEL_COMPLETE = 2'd1;
    localparam logic [SEL_W-1:0] SEL_CONGEST  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_NO_EXT  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    // command kinds handed from front to back
    localparam logic [1:0] K_START  = 2'd0;
    localparam logic [1:0] K_SINGLE = 2'd1;
    localparam logic [1:0] K_VAR    = 2'd2;
    localparam logic [1:0] K_ERR    = 2'd3;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;

    typedef struct packed {
        logic       op;
        logic [7:0] ie_code;
        logic [7:0] content_length;
        logic       drop_empty;
        logic [7:0] msg_type;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_index;
        logic [11:0] ie_offset;
        logic [8:0]  bytes_appended;
    } result_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        status;
        logic [SEL_W-1:0]  sel;
        logic [MAIN_W-1:0] pos;
        logic [8:0]        bytes;
    } cmd_t;

    typedef struct packed {
        logic              hit;
        logic [MAIN_W-1:0] pos;
    } lookup_t;

    function automatic lookup_t code_lookup(input logic [6:0] code);
        lookup_t r;
        r.hit = 1'b1;
        unique case (code)
            7'h04: r.pos = 5'd0;
            7'h08: r.pos = 5'd1;
            7'h10: r.pos = 5'd2;
            7'h14: r.pos = 5'd3;
            7'h18: r.pos = 5'd4;
            7'h1c: r.pos = 5'd5;
            7'h1e: r.pos = 5'd6;
            7'h20: r.pos = 5'd7;
            7'h27: r.pos = 5'd8;
            7'h28: r.pos = 5'd9;
            7'h29: r.pos = 5'd10;
            7'h2c: r.pos = 5'd11;
            7'h34: r.pos = 5'd12;
            7'h40: r.pos = 5'd13;
            7'h42: r.pos = 5'd14;
            7'h43: r.pos = 5'd15;
            7'h44: r.pos = 5'd16;
            7'h45: r.pos = 5'd17;
            7'h46: r.pos = 5'd18;
            7'h47: r.pos = 5'd19;
            7'h4c: r.pos = 5'd20;
            7'h4d: r.pos = 5'd21;
            7'h6c: r.pos = 5'd22;
            7'h6d: r.pos = 5'd23;
            7'h70: r.pos = 5'd24;
            7'h71: r.pos = 5'd25;
            7'h74: r.pos = 5'd26;
            7'h78: r.pos = 5'd27;
            7'h79: r.pos = 5'd28;
            7'h7c: r.pos = 5'd29;
            7'h7d: r.pos = 5'd30;
            7'h7e: r.pos = 5'd31;
            default:
            begin
                r.hit = 1'b0;
                r.pos = '0;
            end
        endcase
        return r;
    endfunction

endpackage

### src/q931_ie_front.sv
// ----------------------------------------------------------------------------
// q931_ie_front
// Accepts input transactions and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module q931_ie_front
    import q931_ie_pkg::*;
(
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  logic  q_full,
    output logic  push,
    output cmd_t  push_data
);

    lookup_t lk;

    assign item_ready = !q_full;
    assign push       = item_valid && !q_full;
    assign lk         = code_lookup(item.ie_code[6:0]);

    always_comb
    begin
        push_data        = '0;
        push_data.status = ST_OK;
        if (item.op == OP_START)
        begin
            push_data.kind = K_START;
        end
        else if ((item.ie_code & SINGLE_FLAG) != '0)
        begin
            push_data.kind  = K_SINGLE;
            push_data.bytes = 9'd1;
            if (item.ie_code == CODE_MORE)
                push_data.sel = SEL_MORE;
            else if (item.ie_code == CODE_COMPLETE)
                push_data.sel = SEL_COMPLETE;
            else if ((item.ie_code & HI_NIBBLE) == CODE_CONGEST)
                push_data.sel = SEL_CONGEST;
            else
            begin
                push_data.kind   = K_ERR;
                push_data.status = ST_UNKNOWN;
            end
        end
        else if (item.content_length == '0 && item.drop_empty)
        begin
            push_data.kind   = K_ERR;
            push_data.status = ST_EMPTY;
        end
        else if (!lk.hit)
        begin
            push_data.kind   = K_ERR;
            push_data.status = ST_UNKNOWN;
        end
        else
        begin
            push_data.kind  = K_VAR;
            push_data.pos   = lk.pos;
            push_data.bytes = 9'(item.content_length) + 9'd2;
        end
    end

endmodule

### src/q931_ie_cmdq.sv
// ----------------------------------------------------------------------------
// q931_ie_cmdq
// Small command queue between the classifier and the index engine.
// ----------------------------------------------------------------------------
module q931_ie_cmdq
    import q931_ie_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic not_empty
);

    cmd_t               ent_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;

    localparam logic [CMDQ_AW:0] DEPTH_CNT = (CMDQ_AW+1)'(CMDQ_DEPTH);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### src/q931_ie_back.sv
// ----------------------------------------------------------------------------
// q931_ie_back
// Index engine: slot bookkeeping, extension chain walk, output register.
// ----------------------------------------------------------------------------
`include "q931_ie_index_builder_macros.svh"

module q931_ie_back
    import q931_ie_pkg::*;
#(
    parameter int EXT_SLOTS = EXT_SLOTS_DEF,
    parameter int MSG_BYTES = MSG_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_not_empty,
    input  cmd_t    q_data,
    output logic    q_pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int EXT_W = (EXT_SLOTS > 1) ? $clog2(EXT_SLOTS) : 1;
    localparam int AP_W  = $clog2(MSG_BYTES + 1);

    localparam logic [EXT_W:0]  EXT_CNT = (EXT_W+1)'(EXT_SLOTS);
    localparam logic [AP_W:0]   MSG_LIM = (AP_W+1)'(MSG_BYTES);
    localparam logic [AP_W-1:0] AP_INIT = AP_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    // slot occupancy; offsets themselves are never read back, only "in use"
    logic [NUM_MAIN-1:0]   main_used_reg, main_used_next;
    logic [NUM_MAIN-1:0]   main_rep_reg, main_rep_next;
    logic [EXT_W-1:0]      main_link_reg [NUM_MAIN];
    logic [EXT_W-1:0]      main_link_next [NUM_MAIN];
    logic [NUM_SINGLE-1:0] single_used_reg, single_used_next;
    logic [EXT_SLOTS-1:0]  ext_used_reg, ext_used_next;
    logic [EXT_SLOTS-1:0]  ext_rep_reg, ext_rep_next;
    logic [EXT_W-1:0]      ext_link_reg [EXT_SLOTS];
    logic [EXT_W-1:0]      ext_link_next [EXT_SLOTS];
    logic [AP_W-1:0]       ap_reg, ap_next;

    cmd_t             cmd_reg, cmd_next;
    logic             tail_main_reg, tail_main_next;
    logic [EXT_W-1:0] tail_reg, tail_next;
    logic             rep_reg, rep_next;
    logic [EXT_W-1:0] nxt_reg, nxt_next;
    logic [EXT_W:0]   steps_reg, steps_next;
    result_t          res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;

    logic             free_found;
    logic [EXT_W-1:0] free_idx;
    logic [AP_W:0]    ap_sum;
    logic             too_big;
    logic [AP_W+11:0] ap_wide;
    logic             walk_more;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assign ap_sum    = {1'b0, ap_reg} + (AP_W+1)'(cmd_reg.bytes);
    assign too_big   = ap_sum > MSG_LIM;
    assign ap_wide   = (AP_W+12)'(ap_reg);
    assign walk_more = rep_reg && ({1'b0, nxt_reg} < EXT_CNT) && (steps_reg < EXT_CNT);

    // lowest free extension slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = EXT_SLOTS - 1; i >= 0; i--)
        begin
            if (!ext_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = EXT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        main_used_next   = main_used_reg;
        main_rep_next    = main_rep_reg;
        main_link_next   = main_link_reg;
        single_used_next = single_used_reg;
        ext_used_next    = ext_used_reg;
        ext_rep_next     = ext_rep_reg;
        ext_link_next    = ext_link_reg;
        ap_next          = ap_reg;
        cmd_next         = cmd_reg;
        tail_main_next   = tail_main_reg;
        tail_next        = tail_reg;
        rep_next         = rep_reg;
        nxt_next         = nxt_reg;
        steps_next       = steps_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        out_data_next    = out_data_reg;
        q_pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_OUT;
                unique case (cmd_reg.kind)
                    K_START:
                    begin
                        main_used_next   = '0;
                        main_rep_next    = '0;
                        single_used_next = '0;
                        ext_used_next    = '0;
                        ext_rep_next     = '0;
                        ap_next          = AP_INIT;
                    end
                    K_ERR:
                    begin
                        res_next.status = cmd_reg.status;
                    end
                    K_SINGLE:
                    begin
                        if (single_used_reg[cmd_reg.sel])
                            res_next.status = ST_DUP;
                        else if (too_big)
                            res_next.status = ST_FULL;
                        else
                        begin
                            single_used_next[cmd_reg.sel] = 1'b1;
                            ap_next                 = ap_sum[AP_W-1:0];
                            res_next.slot_index     = SINGLE_BASE + 6'(cmd_reg.sel);
                            res_next.ie_offset      = ap_wide[11:0];
                            res_next.bytes_appended = cmd_reg.bytes;
                        end
                    end
                    K_VAR:
                    begin
                        if (!main_used_reg[cmd_reg.pos])
                        begin
                            if (too_big)
                                res_next.status = ST_FULL;
                            else
                            begin
                                main_used_next[cmd_reg.pos] = 1'b1;
                                ap_next                 = ap_sum[AP_W-1:0];
                                res_next.slot_index     = 6'(cmd_reg.pos);
                                res_next.ie_offset      = ap_wide[11:0];
                                res_next.bytes_appended = cmd_reg.bytes;
                            end
                        end
                        else
                        begin
                            // repeat: find the chain tail first
                            tail_main_next = 1'b1;
                            tail_next      = '0;
                            rep_next       = main_rep_reg[cmd_reg.pos];
                            nxt_next       = main_link_reg[cmd_reg.pos];
                            steps_next     = '0;
                            state_next     = S_WALK;
                        end
                    end
                endcase
            end

            S_WALK:
            begin
                if (walk_more)
                begin
                    tail_main_next = 1'b0;
                    tail_next      = nxt_reg;
                    rep_next       = ext_rep_reg[nxt_reg];
                    nxt_next       = ext_link_reg[nxt_reg];
                    steps_next     = steps_reg + 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                    if (!free_found)
                        res_next.status = ST_NO_EXT;
                    else if (too_big)
                        res_next.status = ST_FULL;
                    else
                    begin
                        if (tail_main_reg)
                        begin
                            main_link_next[cmd_reg.pos] = free_idx;
                            main_rep_next[cmd_reg.pos]  = 1'b1;
                        end
                        else
                        begin
                            ext_link_next[tail_reg] = free_idx;
                            ext_rep_next[tail_reg]  = 1'b1;
                        end
                        ext_used_next[free_idx] = 1'b1;
                        ext_rep_next[free_idx]  = 1'b0;
                        ext_link_next[free_idx] = '0;
                        ap_next                 = ap_sum[AP_W-1:0];
                        res_next.slot_index     = EXT_BASE + 6'(free_idx);
                        res_next.ie_offset      = ap_wide[11:0];
                        res_next.bytes_appended = cmd_reg.bytes;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            main_used_reg   <= '0;
            main_rep_reg    <= '0;
            single_used_reg <= '0;
            ext_used_reg    <= '0;
            ext_rep_reg     <= '0;
            ap_reg          <= AP_INIT;
            steps_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            main_used_reg   <= main_used_next;
            main_rep_reg    <= main_rep_next;
            single_used_reg <= single_used_next;
            ext_used_reg    <= ext_used_next;
            ext_rep_reg     <= ext_rep_next;
            ap_reg          <= ap_next;
            steps_reg       <= steps_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_link_reg <= main_link_next;
        ext_link_reg  <= ext_link_next;
        cmd_reg       <= cmd_next;
        tail_main_reg <= tail_main_next;
        tail_reg      <= tail_next;
        rep_reg       <= rep_next;
        nxt_reg       <= nxt_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    `Q931_IE_ASSERT(a_ap_nonzero, ap_reg != '0, "append pointer dropped to zero")
    `Q931_IE_ASSERT(a_steps_bound, steps_reg <= EXT_CNT, "chain walk ran past its bound")
    `Q931_IE_ASSERT_NXT(a_start_clears, state_reg == S_EXEC && cmd_reg.kind == K_START,
        ext_used_reg == '0 && main_used_reg == '0 && ap_reg == AP_INIT, "start left index dirty")
    `Q931_IE_ASSERT_NXT(a_out_load, state_reg == S_OUT && (!out_valid_reg || result_ready),
        out_valid_reg && state_reg == S_IDLE, "finished result not loaded")
    `Q931_IE_ASSERT_IMP(a_err_no_slot, out_valid_reg && result.status != ST_OK,
        result.slot_index == '0 && result.bytes_appended == '0, "error result carries a slot")

endmodule

### src/q931_ie_index_builder.sv
// ----------------------------------------------------------------------------
// q931_ie_index_builder
// Q.931 message IE index builder: classifier, command queue, index engine.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  item     | in        | item_valid / item_ready     | item_t
//  result   | out       | result_valid / result_ready | result_t
//
//  Start, error, single-octet and first-occurrence items take the engine through
//  its idle, execute and output states; a repeated variable code adds a walk
//  state that follows one chain link per cycle, at most EXT_SLOTS links.
//  Reset leaves an empty index, append pointer 1; a start item clears the index.
//  Input keeps being taken while the 2-entry queue has room; a stalled
//  result holds the engine in its output state only.
// ----------------------------------------------------------------------------
module q931_ie_index_builder
    import q931_ie_pkg::*;
#(
    parameter int EXT_SLOTS = EXT_SLOTS_DEF,
    parameter int MSG_BYTES = MSG_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic q_full;
    logic q_push;
    cmd_t q_push_data;
    logic q_pop;
    cmd_t q_pop_data;
    logic q_not_empty;

    q931_ie_front u_front
    (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    q931_ie_cmdq u_cmdq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    q931_ie_back
    #(
        .EXT_SLOTS (EXT_SLOTS),
        .MSG_BYTES (MSG_BYTES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
